// ===== rtl/evad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_pkg: shared types and constants of the energy voice activity detector
// Sample and count widths, register indexes and reset values, the register
// bundle, the queued end-of-window job and the state encodings.
// ----------------------------------------------------------------------------
package evad_pkg;

	// widths of the datapath
	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 16;
	localparam int SUM_WIDTH    = 31;
	localparam int ALPHA_WIDTH  = 16;
	localparam int THR_WIDTH    = 16;
	localparam int FLOOR_WIDTH  = 15;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 16;

	// filter arithmetic: difference, product and rounded result widths
	localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 2;
	localparam int PROD_WIDTH  = DIFF_WIDTH + ALPHA_WIDTH + 1;
	localparam int FRAC_BITS   = 16;
	localparam int YWIDE_WIDTH = PROD_WIDTH - FRAC_BITS;
	localparam int THR_FRAC_BITS = 12;

	// decision multiplier
	localparam int MUL_WIDTH = 32;
	localparam int MPROD_WIDTH = 2 * MUL_WIDTH;

	// queue between front end and decision unit
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// register reset values
	localparam logic [COUNT_WIDTH-1:0] RST_WINDOW_LEN = COUNT_WIDTH'(48000);
	localparam logic [COUNT_WIDTH-1:0] RST_LAST_LEN   = COUNT_WIDTH'(8000);
	localparam logic                   RST_HPF_ENABLE = 1'b1;
	localparam logic [ALPHA_WIDTH-1:0] RST_HPF_ALPHA  = ALPHA_WIDTH'(4772);
	localparam logic [THR_WIDTH-1:0]   RST_THRESHOLD  = THR_WIDTH'(1229);
	localparam logic [FLOOR_WIDTH-1:0] RST_SIL_FLOOR  = FLOOR_WIDTH'(3);

	// register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_WINDOW_LEN    = 3'd0,
		REG_LAST_LEN      = 3'd1,
		REG_HPF_ENABLE    = 3'd2,
		REG_HPF_ALPHA     = 3'd3,
		REG_VAD_THRESHOLD = 3'd4,
		REG_SILENCE_FLOOR = 3'd5
	} reg_index_t;

	// register bundle
	typedef struct packed {
		logic [COUNT_WIDTH-1:0] window_len;
		logic [COUNT_WIDTH-1:0] last_len;
		logic                   hpf_enable;
		logic [ALPHA_WIDTH-1:0] hpf_alpha;
		logic [THR_WIDTH-1:0]   vad_threshold;
		logic [FLOOR_WIDTH-1:0] silence_floor;
	} cfg_t;

	// finished window sums handed to the decision unit
	typedef struct packed {
		logic [SUM_WIDTH-1:0] sum_all;
		logic [SUM_WIDTH-1:0] sum_last;
	} job_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_ACC
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FA,
		BK_FL,
		BK_LL,
		BK_TL,
		BK_TS,
		BK_CMP
	} back_state_t;

	// effective window length: zero acts as one
	function automatic logic [COUNT_WIDTH-1:0] eff_len(input logic [COUNT_WIDTH-1:0] wl);
		eff_len = (wl == '0) ? COUNT_WIDTH'(1) : wl;
	endfunction

endpackage

// ===== rtl/evad_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_front: sample filter and energy accumulator
// Takes one sample at a time, runs the optional high-pass filter through its
// difference, multiply and round/accumulate steps and keeps the window and
// recent-segment sums; at the end of a window it hands the sums to the decision queue.
// ----------------------------------------------------------------------------
module evad_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  evad_pkg::cfg_t                         cfg,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [evad_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                   q_push,
	input  logic                                   q_full,
	output evad_pkg::job_t                         q_data
);
	import evad_pkg::*;

	front_state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0]         idx_q;
	logic signed [SAMPLE_WIDTH-1:0] px_q;
	logic signed [SAMPLE_WIDTH-1:0] fo_q;
	logic [SUM_WIDTH-1:0]           sum_all_q;
	logic [SUM_WIDTH-1:0]           sum_last_q;

	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic                           bypass_s1;
	logic signed [DIFF_WIDTH-1:0]   d_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s2;
	logic                           bypass_s2;
	logic signed [PROD_WIDTH-1:0]   prod_s2;

	logic                           accept;
	logic                           commit;
	logic signed [DIFF_WIDTH-1:0]   d_next;
	logic signed [ALPHA_WIDTH:0]    alpha_s;
	logic signed [PROD_WIDTH-1:0]   rnd;
	logic signed [YWIDE_WIDTH-1:0]  y_wide;
	logic [YWIDE_WIDTH-SAMPLE_WIDTH:0] y_hi;
	logic signed [SAMPLE_WIDTH-1:0] y_filt;
	logic signed [SAMPLE_WIDTH-1:0] y;
	logic [SAMPLE_WIDTH-1:0]        mag;
	logic [COUNT_WIDTH-1:0]         len;
	logic [COUNT_WIDTH-1:0]         start;
	logic                           in_last;
	logic                           last_sample;
	logic [SUM_WIDTH:0]             all_add;
	logic [SUM_WIDTH:0]             last_add;
	logic [SUM_WIDTH-1:0]           all_next;
	logic [SUM_WIDTH-1:0]           last_next;

	// difference term of the filter, from the current history
	assign d_next = DIFF_WIDTH'(fo_q) + DIFF_WIDTH'(sample) - DIFF_WIDTH'(px_q);
	assign alpha_s = $signed({1'b0, cfg.hpf_alpha});

	// round half up, floor shift, saturate to the sample range
	assign rnd    = prod_s2 + PROD_WIDTH'(32'sd32768);
	assign y_wide = rnd[PROD_WIDTH-1:FRAC_BITS];
	assign y_hi   = y_wide[YWIDE_WIDTH-1:SAMPLE_WIDTH-1];

	always_comb begin
		if ((&y_hi) || !(|y_hi)) begin
			y_filt = y_wide[SAMPLE_WIDTH-1:0];
		end else if (y_wide[YWIDE_WIDTH-1]) begin
			y_filt = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			y_filt = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	assign y   = bypass_s2 ? x_s2 : y_filt;
	assign mag = y[SAMPLE_WIDTH-1] ? (~y + SAMPLE_WIDTH'(1)) : y;

	// window position and recent segment membership
	assign len         = eff_len(cfg.window_len);
	assign start       = (cfg.last_len >= len) ? '0 : (len - cfg.last_len);
	assign in_last     = (idx_q >= start);
	assign last_sample = ({1'b0, idx_q} + (COUNT_WIDTH+1)'(1)) >= {1'b0, len};

	// saturating sums
	assign all_add   = {1'b0, sum_all_q} + (SUM_WIDTH+1)'(mag);
	assign last_add  = {1'b0, sum_last_q} + (SUM_WIDTH+1)'(mag);
	assign all_next  = all_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : all_add[SUM_WIDTH-1:0];
	assign last_next = !in_last ? sum_last_q :
		(last_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : last_add[SUM_WIDTH-1:0]);

	assign q_data.sum_all  = all_next;
	assign q_data.sum_last = last_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		accept  = 1'b0;
		commit  = 1'b0;
		q_push  = 1'b0;
		case (state_q)
			FR_IDLE: begin
				full   = 1'b0;
				accept = push;
				if (push) begin
					state_d = FR_MUL;
				end
			end
			FR_MUL: begin
				state_d = FR_ACC;
			end
			FR_ACC: begin
				if (!last_sample || !q_full) begin
					commit  = 1'b1;
					q_push  = last_sample;
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	// sample and product pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1      <= sample;
			d_s1      <= d_next;
			bypass_s1 <= (idx_q == '0) || !cfg.hpf_enable;
		end
		if (state_q == FR_MUL) begin
			x_s2      <= x_s1;
			bypass_s2 <= bypass_s1;
			prod_s2   <= PROD_WIDTH'(d_s1) * PROD_WIDTH'(alpha_s);
		end
	end

	// filter history, position and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			px_q       <= '0;
			fo_q       <= '0;
			sum_all_q  <= '0;
			sum_last_q <= '0;
		end else if (commit) begin
			px_q <= x_s2;
			fo_q <= y;
			if (last_sample) begin
				idx_q      <= '0;
				sum_all_q  <= '0;
				sum_last_q <= '0;
			end else begin
				idx_q      <= idx_q + COUNT_WIDTH'(1);
				sum_all_q  <= all_next;
				sum_last_q <= last_next;
			end
		end
	end

`ifndef SYNTHESIS
	// a taken sample keeps the input closed while it is filtered
	assert property (@(posedge clk) disable iff (!arst_n) (push && !full) |=> full)
		else $error("evad_front: input open right after a sample was taken");
	// the queue never sees a push while it is full
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("evad_front: push into a full queue");
`endif

endmodule

// ===== rtl/evad_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_queue: short job queue
// Holds finished window sums between the front end and the decision unit so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module evad_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  evad_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output evad_pkg::job_t pop_data,
	output logic           empty
);
	import evad_pkg::*;

	job_t                  entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// a pop is only requested when a job is waiting
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("evad_queue: pop from an empty queue");
	// the fill count follows the transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + QUEUE_CW'(1)))
		else $error("evad_queue: fill count lost a push");
`endif

endmodule

// ===== rtl/evad_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_back: end-of-window decision unit
// Takes one job from the queue and runs the silence and loudness
// cross-multiplications on one shared 32x32 multiplier, then loads the result
// register that faces the output side.
// ----------------------------------------------------------------------------
module evad_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  evad_pkg::cfg_t                       cfg,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  evad_pkg::job_t                       q_data,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 speech_ended,
	output logic                                 too_short,
	output logic [evad_pkg::SUM_WIDTH-1:0]       energy_all_sum,
	output logic [evad_pkg::SUM_WIDTH-1:0]       energy_last_sum
);
	import evad_pkg::*;

	back_state_t state_q, state_d;

	job_t                   job_q;
	logic [MPROD_WIDTH-1:0] p_q;
	logic [MPROD_WIDTH-1:0] lhs_q;
	logic                   all_quiet_q;
	logic                   silent_q;
	logic                   out_valid_q;
	logic                   ended_q;
	logic                   short_q;
	logic [SUM_WIDTH-1:0]   all_q;
	logic [SUM_WIDTH-1:0]   last_q;

	logic [COUNT_WIDTH-1:0] len;
	logic [MUL_WIDTH-1:0]   mul_a;
	logic [MUL_WIDTH-1:0]   mul_b;
	logic [MPROD_WIDTH-1:0] mul_p;
	logic                   mul_en;
	logic                   out_load;
	logic                   short_now;
	logic                   loud;

	assign len       = eff_len(cfg.window_len);
	assign short_now = (cfg.last_len == '0) || (cfg.last_len >= len);
	assign loud      = (lhs_q > p_q);
	assign mul_p     = MPROD_WIDTH'(mul_a) * MPROD_WIDTH'(mul_b);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			BK_FA: begin
				mul_a = MUL_WIDTH'(cfg.silence_floor);
				mul_b = MUL_WIDTH'(len);
			end
			BK_FL: begin
				mul_a = MUL_WIDTH'(cfg.silence_floor);
				mul_b = MUL_WIDTH'(cfg.last_len);
			end
			BK_LL: begin
				mul_a = MUL_WIDTH'(job_q.sum_last);
				mul_b = MUL_WIDTH'(len);
			end
			BK_TL: begin
				mul_a = MUL_WIDTH'(cfg.vad_threshold);
				mul_b = MUL_WIDTH'(cfg.last_len);
			end
			BK_TS: begin
				mul_a = p_q[MUL_WIDTH-1:0];
				mul_b = MUL_WIDTH'(job_q.sum_all);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mul_en   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_FA;
				end
			end
			BK_FA: begin
				mul_en  = 1'b1;
				state_d = BK_FL;
			end
			BK_FL: begin
				mul_en  = 1'b1;
				state_d = BK_LL;
			end
			BK_LL: begin
				mul_en  = 1'b1;
				state_d = BK_TL;
			end
			BK_TL: begin
				mul_en  = 1'b1;
				state_d = BK_TS;
			end
			BK_TS: begin
				mul_en  = 1'b1;
				state_d = BK_CMP;
			end
			BK_CMP: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// job, products and partial decisions
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (mul_en) begin
			p_q <= mul_p;
		end
		if (state_q == BK_FL) begin
			all_quiet_q <= MPROD_WIDTH'(job_q.sum_all) < p_q;
		end
		if (state_q == BK_LL) begin
			silent_q <= all_quiet_q && (MPROD_WIDTH'(job_q.sum_last) < p_q);
		end
		if (state_q == BK_TL) begin
			lhs_q <= p_q << THR_FRAC_BITS;
		end
		if (out_load) begin
			ended_q <= !short_now && !silent_q && !loud;
			short_q <= short_now;
			all_q   <= job_q.sum_all;
			last_q  <= job_q.sum_last;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty           = !out_valid_q;
	assign speech_ended    = ended_q;
	assign too_short       = short_q;
	assign energy_all_sum  = all_q;
	assign energy_last_sum = last_q;

`ifndef SYNTHESIS
	// a result is never written over one that waits
	assert property (@(posedge clk) disable iff (!arst_n) out_load |-> (!out_valid_q || pop))
		else $error("evad_back: result overwritten before it was taken");
	// a job only leaves the queue when the unit is free
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> (state_q == BK_IDLE && !q_empty))
		else $error("evad_back: job taken while busy");
`endif

endmodule

// ===== rtl/energy_voice_activity_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_top: energy voice activity detector
// A window result passes the front end, job queue and decision unit in turn.
// The front end takes a new sample only after the current one has passed the
// filter difference, multiply and round/accumulate steps of the front end.
// The decision unit works on one window at a time on its shared multiplier.
// Reset (arst_n low) restores register defaults, clears sums, filter history.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [evad_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   speech_ended,
	output logic                                   too_short,
	output logic [evad_pkg::SUM_WIDTH-1:0]         energy_all_sum,
	output logic [evad_pkg::SUM_WIDTH-1:0]         energy_last_sum,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [evad_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [evad_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
	import evad_pkg::*;

	cfg_t cfg_q;
	job_t q_in;
	job_t q_out;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len    <= RST_WINDOW_LEN;
			cfg_q.last_len      <= RST_LAST_LEN;
			cfg_q.hpf_enable    <= RST_HPF_ENABLE;
			cfg_q.hpf_alpha     <= RST_HPF_ALPHA;
			cfg_q.vad_threshold <= RST_THRESHOLD;
			cfg_q.silence_floor <= RST_SIL_FLOOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_LEN:    cfg_q.window_len    <= COUNT_WIDTH'(cfg_data);
				REG_LAST_LEN:      cfg_q.last_len      <= COUNT_WIDTH'(cfg_data);
				REG_HPF_ENABLE:    cfg_q.hpf_enable    <= cfg_data[0];
				REG_HPF_ALPHA:     cfg_q.hpf_alpha     <= ALPHA_WIDTH'(cfg_data);
				REG_VAD_THRESHOLD: cfg_q.vad_threshold <= THR_WIDTH'(cfg_data);
				REG_SILENCE_FLOOR: cfg_q.silence_floor <= cfg_data[FLOOR_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// filter and accumulation front end
	evad_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.full   (full),
		.sample (sample),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (q_in)
	);

	// job queue
	evad_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	// decision unit and result register
	evad_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.q_data          (q_out),
		.empty           (empty),
		.pop             (pop),
		.speech_ended    (speech_ended),
		.too_short       (too_short),
		.energy_all_sum  (energy_all_sum),
		.energy_last_sum (energy_last_sum)
	);

`ifndef SYNTHESIS
	// a result of a too short window never flags speech end
	assert property (@(posedge clk) disable iff (!arst_n) (!empty && too_short) |-> !speech_ended)
		else $error("top: speech end flagged on a too short window");
`endif

endmodule
